// ===== sv/pwm_divider_wrap_calculator_defines.svh =====
`ifndef PWM_DIVIDER_WRAP_CALCULATOR_DEFINES_SVH
`define PWM_DIVIDER_WRAP_CALCULATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define PDW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PDW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pdw_pkg.sv =====
`default_nettype none

package pdw_pkg;

  localparam int DIV_STEPS = 32;
  localparam int CNT_W = $clog2(DIV_STEPS);

  localparam logic [27:0] SRC_CLK_RESET = 28'd125000000;

  // exact reciprocals for 32-bit operands: x/5 = (x*R5)>>34, x/3 = (x*R3)>>33
  localparam logic [31:0] RECIP5 = 32'hCCCCCCCD;
  localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;

  localparam logic [31:0] MIN_DIV5 = 32'd80;
  localparam logic [31:0] MIN_DIV3 = 32'd48;
  localparam logic [31:0] MIN_DIV2 = 32'd32;
  localparam logic [31:0] DIV_LOW = 32'd16;
  localparam logic [31:0] DIV_HIGH = 32'd4096;
  localparam logic [15:0] LEVEL_FULL = 16'hFFFF;

  typedef struct packed {
    logic [27:0] requested_freq;
    logic [15:0] duty;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [11:0] divider_8p4;
    logic [15:0] wrap_top;
    logic [15:0] compare_level;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic recip;
    logic fstep;
    logic mult;
    logic scale;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic no_move;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/pdw_datapath.sv =====
`default_nettype none

`include "pwm_divider_wrap_calculator_defines.svh"

module pdw_datapath import pdw_pkg::*; #(
  parameter int TOP_LIMIT = 65534
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [27:0] cfg_data,
  input  wire in_item_t    in_data,
  input  wire cmd_t        cmd,
  output status_t          status,
  output out_item_t        out_data
);

  localparam logic [18:0] LIM = 19'(TOP_LIMIT);

  logic [27:0]      src_clk;
  logic [27:0]      freq;
  logic [15:0]      duty;
  logic [27:0]      rem;
  logic [31:0]      quot;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      top;
  logic [29:0]      q5;
  logic [30:0]      q3;
  logic [31:0]      prod;

  logic [28:0] trial;
  logic        ge;
  logic [63:0] p5;
  logic [63:0] p3;
  logic [31:0] q5x5;
  logic [31:0] q3x3;
  logic [18:0] top5;
  logic [17:0] top3;
  logic [16:0] top2;
  logic        mv5;
  logic        mv3;
  logic        mv2;
  logic [15:0] pa;
  logic [15:0] pb;
  logic [16:0] psum;
  logic [1:0]  corr;
  logic [15:0] level;
  logic        ok_final;

  // restoring division of 16*source clock by the frequency
  assign trial = {rem, quot[31]};
  assign ge    = trial >= {1'b0, freq};

  assign p5   = {32'd0, quot} * {32'd0, RECIP5};
  assign p3   = {32'd0, quot} * {32'd0, RECIP3};
  assign q5x5 = {q5, 2'b00} + {2'b00, q5};
  assign q3x3 = {q3, 1'b0} + {1'b0, q3};
  assign top5 = {1'b0, top, 2'b00} + {3'b000, top};
  assign top3 = {1'b0, top, 1'b0} + {2'b00, top};
  assign top2 = {top, 1'b0};

  assign mv5 = (quot >= MIN_DIV5) && (q5x5 == quot) && (top5 <= LIM);
  assign mv3 = (quot >= MIN_DIV3) && (q3x3 == quot) && ({1'b0, top3} <= LIM);
  assign mv2 = (quot >= MIN_DIV2) && ({2'b00, top2} <= LIM);

  assign status.div_last = cnt == CNT_W'(DIV_STEPS - 1);
  assign status.no_move  = !(mv5 || mv3 || mv2);

  // x/65535 for x = a*2^16 + b is a + (a+b)/65535, and (a+b)/65535 is at most 2
  assign pa    = prod[31:16];
  assign pb    = prod[15:0];
  assign psum  = {1'b0, pa} + {1'b0, pb};
  assign corr  = (psum >= {LEVEL_FULL, 1'b0}) ? 2'd2 :
                 (psum >= {1'b0, LEVEL_FULL}) ? 2'd1 : 2'd0;
  assign level = pa + {14'd0, corr};

  assign ok_final = (freq != 28'd0) && (quot >= DIV_LOW) && (quot < DIV_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_clk <= SRC_CLK_RESET;
    end else if (cfg_we) begin
      src_clk <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= 16'd1;
    end else if (cmd.load) begin
      top <= 16'd1;
    end else if (cmd.fstep) begin
      if (mv5) begin
        top <= top5[15:0];
      end else if (mv3) begin
        top <= top3[15:0];
      end else if (mv2) begin
        top <= top2[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq <= in_data.requested_freq;
      duty <= in_data.duty;
      rem  <= 28'd0;
      quot <= {src_clk, 4'b0000};
      cnt  <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? 28'(trial - {1'b0, freq}) : trial[27:0];
      quot <= {quot[30:0], ge};
      cnt  <= cnt + CNT_W'(1);
    end else if (cmd.fstep) begin
      if (mv5) begin
        quot <= {2'b00, q5};
      end else if (mv3) begin
        quot <= {1'b0, q3};
      end else if (mv2) begin
        quot <= {1'b0, quot[31:1]};
      end
    end
    if (cmd.recip) begin
      q5 <= p5[63:34];
      q3 <= p3[63:33];
    end
    if (cmd.mult) begin
      prod <= {16'd0, duty} * ({16'd0, top} + 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_data <= '0;
    end else if (cmd.scale) begin
      if (ok_final) begin
        out_data.ok            <= 1'b1;
        out_data.divider_8p4   <= quot[11:0];
        out_data.wrap_top      <= top;
        out_data.compare_level <= level;
      end else begin
        out_data <= '0;
      end
    end
  end

  `PDW_ASSERT_IMP(a_top_limit, 1'b1, {3'b000, top} <= LIM, "wrap count above limit")
  `PDW_ASSERT_NXT(a_div_shrinks, cmd.fstep && !status.no_move, quot < $past(quot), "divider did not shrink")
  `PDW_ASSERT_NXT(a_fail_zero, cmd.scale && !ok_final, out_data == '0, "failure result not cleared")
  `PDW_ASSERT_NXT(a_level_bound, cmd.scale && ok_final, {1'b0, out_data.compare_level} <= {1'b0, out_data.wrap_top} + 17'd1, "compare level above wrap")

endmodule

`default_nettype wire

// ===== sv/pdw_ctrl.sv =====
`default_nettype none

`include "pwm_divider_wrap_calculator_defines.svh"

module pdw_ctrl import pdw_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_RECIP = 6'b000100,
    ST_STEP  = 6'b001000,
    ST_MULT  = 6'b010000,
    ST_SCALE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_RECIP;
        end
      end
      ST_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = ST_STEP;
      end
      ST_STEP: begin
        cmd.fstep  = 1'b1;
        state_next = status.no_move ? ST_MULT : ST_RECIP;
      end
      ST_MULT: begin
        cmd.mult   = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        // wait until the output register is free
        if (out_free) begin
          cmd.scale  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.scale) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `PDW_ASSERT_IMP(a_no_overwrite, cmd.scale, !out_valid || out_ready, "result overwritten")
  `PDW_ASSERT_NXT(a_accept_start, in_valid && in_ready, state == ST_DIV, "division not started")
  `PDW_ASSERT_NXT(a_div_end, state == ST_DIV && status.div_last, state == ST_RECIP, "division overran")

endmodule

`default_nettype wire

// ===== sv/pwm_divider_wrap_calculator.sv =====
// PWM divider and wrap calculator.
// Input channel (in_valid/in_ready/in_data) carries a request: the desired
// PWM frequency and a 16-bit duty. Output channel (out_valid/out_ready/
// out_data) returns one result per request: ok flag, 8.4 clock divider,
// counter wrap value and compare level; all zero on failure.
// cfg_we/cfg_data write the source clock frequency; write only while idle.
// One request at a time. After acceptance the block runs a restoring
// division, then factoring steps (each one reciprocal multiply and one
// check/update, at most 15 moves plus the final check), then a multiply
// and a scaling step before out_valid rises. The division loop and the
// factoring loop set how long a request takes.
// A new request is taken as soon as the core is back in idle, even while
// the previous result still waits in the output register; if the receiver
// stalls, the next result waits in its last cycle until that register frees.
// Reset (rst, synchronous) returns to idle, drops out_valid and loads the
// source clock register with 125 MHz.
`default_nettype none

module pwm_divider_wrap_calculator import pdw_pkg::*; #(
  parameter int TOP_LIMIT = 65534
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [27:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data
);

  cmd_t    cmd;
  status_t status;

  pdw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pdw_datapath #(
    .TOP_LIMIT (TOP_LIMIT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
